// ===== src/bofc_pkg.sv =====
// shared constants, codes and control types of the backlight controller
package bofc_pkg;

	localparam int LVL_W  = 14;
	localparam int PCT_W  = 8;
	localparam int DUR_W  = 16;
	localparam int FI_W   = 16;
	localparam int STEP_W = 6;
	localparam int DEC_W  = 8;
	localparam int DVS_W  = 7;
	localparam int MODE_W = 2;
	localparam int IN_W   = PCT_W + DUR_W;
	localparam int OUT_W  = LVL_W + MODE_W;
	localparam int RCP_W  = 13;

	localparam logic [LVL_W-1:0]  FULL_SCALE    = LVL_W'(8499);
	localparam logic [STEP_W-1:0] FADE_STEPS    = STEP_W'(50);
	localparam logic [DVS_W-1:0]  PCT_MAX       = DVS_W'(100);
	localparam logic [FI_W-1:0]   FADE_INT_RST  = FI_W'(80);

	// level / fade steps as a reciprocal multiply, exact over the level range
	localparam int                DEC_SHIFT = 18;
	localparam logic [RCP_W-1:0]  DEC_RECIP =
		RCP_W'(((1 << DEC_SHIFT) + int'(FADE_STEPS) - 1) / int'(FADE_STEPS));

	localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FADE = 2'd2;

	localparam logic [1:0] DSEL_QUO = 2'd0;
	localparam logic [1:0] DSEL_LVL = 2'd1;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic [1:0] div_sel;
		logic       take_level;
		logic       commit;
	} bofc_cmd_t;

	typedef struct packed {
		logic is_on_cmd;
		logic pct_zero;
		logic div_done;
	} bofc_sts_t;

endpackage

// ===== src/bofc_div.sv =====
// restoring divider, one quotient bit per cycle
module bofc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bofc_pkg::LVL_W-1:0]   dividend,
	input  logic [bofc_pkg::DVS_W-1:0]   divisor,
	output logic [bofc_pkg::LVL_W-1:0]   quotient,
	output logic                         done
);
	import bofc_pkg::*;

	localparam int CNT_W = $clog2(LVL_W + 1);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	logic [DVS_W-1:0] rem_q;
	logic [LVL_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             bit_ok;

	assign rem_sh  = {rem_q, quo_q[LVL_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign bit_ok  = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				count_q <= CNT_W'(LVL_W);
			end else if (count_q != '0) begin
				count_q <= count_q - 1'b1;
				if (count_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (count_q != '0) begin
			rem_q <= bit_ok ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[LVL_W-2:0], bit_ok};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/bofc_dp.sv =====
// datapath: item latch, level scaling, on timer, fade state and config register
module bofc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bofc_pkg::bofc_cmd_t           cmd,
	output bofc_pkg::bofc_sts_t           sts,
	input  logic                          in_action,
	input  logic [bofc_pkg::PCT_W-1:0]    in_pct,
	input  logic [bofc_pkg::DUR_W-1:0]    in_dur,
	input  logic                          fi_we,
	input  logic [bofc_pkg::FI_W-1:0]     fi_wdata,
	output logic [bofc_pkg::LVL_W-1:0]    level,
	output logic [bofc_pkg::MODE_W-1:0]   mode
);
	import bofc_pkg::*;

	localparam int PROD_W = LVL_W + RCP_W;

	logic                action_q;
	logic [DVS_W-1:0]    pct_q;
	logic [DUR_W-1:0]    dur_q;
	logic [LVL_W-1:0]    new_level_q;
	logic [FI_W-1:0]     fade_int_q;

	logic [MODE_W-1:0]   mode_q;
	logic [LVL_W-1:0]    level_q;
	logic [DUR_W-1:0]    on_rem_q;
	logic [STEP_W-1:0]   steps_q;
	logic [DEC_W-1:0]    dec_q;
	logic [FI_W-1:0]     icount_q;

	logic [MODE_W-1:0]   mode_d;
	logic [LVL_W-1:0]    level_d;
	logic [DUR_W-1:0]    on_rem_d;
	logic [STEP_W-1:0]   steps_d;
	logic [DEC_W-1:0]    dec_d;
	logic [FI_W-1:0]     icount_d;

	logic [LVL_W-1:0]    div_dividend;
	logic [DVS_W-1:0]    div_divisor;
	logic [LVL_W-1:0]    div_quo;
	logic                div_done;
	logic [FI_W-1:0]     icount_inc;
	logic [STEP_W-1:0]   steps_dec;
	logic [PROD_W-1:0]   dec_prod;

	bofc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_comb begin
		unique case (cmd.div_sel)
			DSEL_QUO: begin
				div_dividend = LVL_W'(PCT_MAX);
				div_divisor  = pct_q;
			end
			default: begin
				div_dividend = FULL_SCALE;
				div_divisor  = div_quo[DVS_W-1:0];
			end
		endcase
	end

	assign sts.is_on_cmd = action_q;
	assign sts.pct_zero  = pct_q == '0;
	assign sts.div_done  = div_done;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			pct_q    <= (in_pct > PCT_W'(PCT_MAX)) ? PCT_MAX : in_pct[DVS_W-1:0];
			dur_q    <= in_dur;
		end
		if (cmd.take_level) begin
			new_level_q <= div_quo;
		end
	end

	assign icount_inc = icount_q + 1'b1;
	assign steps_dec  = (steps_q != '0) ? steps_q - 1'b1 : steps_q;
	assign dec_prod   = PROD_W'(new_level_q) * PROD_W'(DEC_RECIP);

	always_comb begin
		mode_d   = mode_q;
		level_d  = level_q;
		on_rem_d = on_rem_q;
		steps_d  = steps_q;
		dec_d    = dec_q;
		icount_d = icount_q;
		if (action_q) begin
			mode_d   = MODE_ON;
			on_rem_d = dur_q;
			level_d  = (pct_q == '0) ? '0 : new_level_q;
			dec_d    = (pct_q == '0) ? '0 : dec_prod[DEC_SHIFT +: DEC_W];
		end else if (mode_q == MODE_ON) begin
			if (on_rem_q == '0) begin
				mode_d   = MODE_FADE;
				steps_d  = FADE_STEPS;
				icount_d = '0;
			end else begin
				on_rem_d = on_rem_q - 1'b1;
			end
		end else if (mode_q == MODE_FADE) begin
			icount_d = icount_inc;
			if (icount_inc >= fade_int_q) begin
				icount_d = '0;
				level_d  = (level_q >= LVL_W'(dec_q)) ? level_q - LVL_W'(dec_q) : '0;
				steps_d  = steps_dec;
				if (steps_dec == '0) begin
					mode_d  = MODE_OFF;
					level_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			level_q    <= '0;
			on_rem_q   <= '0;
			steps_q    <= FADE_STEPS;
			dec_q      <= '0;
			icount_q   <= '0;
			fade_int_q <= FADE_INT_RST;
		end else begin
			if (fi_we) begin
				fade_int_q <= fi_wdata;
			end
			if (cmd.commit) begin
				mode_q   <= mode_d;
				level_q  <= level_d;
				on_rem_q <= on_rem_d;
				steps_q  <= steps_d;
				dec_q    <= dec_d;
				icount_q <= icount_d;
			end
		end
	end

	assign level = level_q;
	assign mode  = mode_q;

endmodule

// ===== src/bofc_ctrl.sv =====
// controller: request sequencing, divider steps and output valid
module bofc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bofc_pkg::bofc_cmd_t  cmd,
	input  bofc_pkg::bofc_sts_t  sts
);
	import bofc_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_DIV_QUO  = 3'd2;
	localparam logic [2:0] ST_DIV_LVL  = 3'd3;
	localparam logic [2:0] ST_COMMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       valid_q;
	logic       out_free;

	assign out_free = !valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DSEL_QUO;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.is_on_cmd && !sts.pct_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_QUO;
					state_d       = ST_DIV_QUO;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_DIV_QUO: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_LVL;
					state_d       = ST_DIV_LVL;
				end
			end
			ST_DIV_LVL: begin
				if (sts.div_done) begin
					cmd.take_level = 1'b1;
					state_d        = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = valid_q;

endmodule

// ===== src/backlight_on_timeout_fade_controller.sv =====
// top level of the backlight on-timeout and fade controller
//
// input stream: one request per millisecond tick (s_tuser = 0) or per turn-on
// command (s_tuser = 1, s_tdata carries percent and on time). every request
// yields one result on the output stream: the pwm compare level and the mode
// (off, on, fading) after that request.
// fade_interval_we writes the fade step spacing in ticks; write it while idle.
// requests are handled one at a time. a tick or a zero-percent command goes from
// acceptance through the dispatch and commit states to a registered result; a
// turn-on command with a nonzero percent first makes two passes through the
// shared 14-step restoring divider (100 / percent, full scale / that quotient).
// s_tready is high only while the controller is idle.
// the result sits in an output register; the next request is accepted while
// it waits, but its own result is held back until the receiver takes the
// previous one. a stalled receiver therefore stops intake after one request.
// after reset the light is off at level 0 and fade_interval is 80.
module backlight_on_timeout_fade_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bofc_pkg::IN_W-1:0]     s_tdata,   // on_pct, duration_ms
	input  logic                          s_tuser,   // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bofc_pkg::OUT_W-1:0]    m_tdata,   // pwm_level, light_mode
	input  logic                          fade_interval_we,
	input  logic [bofc_pkg::FI_W-1:0]     fade_interval_wdata
);
	import bofc_pkg::*;

	bofc_cmd_t         cmd;
	bofc_sts_t         sts;
	logic [LVL_W-1:0]  level;
	logic [MODE_W-1:0] mode;

	bofc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bofc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_action (s_tuser),
		.in_pct    (s_tdata[PCT_W-1:0]),
		.in_dur    (s_tdata[IN_W-1:PCT_W]),
		.fi_we     (fade_interval_we),
		.fi_wdata  (fade_interval_wdata),
		.level     (level),
		.mode      (mode)
	);

	assign m_tdata = {mode, level};

endmodule

// ===== src/bofc_chk.sv =====
// port-level checks of the backlight controller and their binding
module bofc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bofc_pkg::OUT_W-1:0]  m_tdata
);
	import bofc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	a_off_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_W-1:LVL_W] == MODE_OFF |-> m_tdata[LVL_W-1:0] == '0)
		else $error("light off with nonzero level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LVL_W-1:0] <= FULL_SCALE)
		else $error("level above full scale");

endmodule

bind backlight_on_timeout_fade_controller bofc_chk u_bofc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
